// File: design/fbpa_pkg.sv
`default_nettype none
package fbpa_pkg;

  // pool geometry
  localparam int BLOCKS   = 256;
  localparam int CHUNKS   = 4;
  localparam int TOTAL    = BLOCKS * CHUNKS;
  localparam int HANDLE_W = 10;
  localparam int BLK_W    = $clog2(BLOCKS);
  localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W    = $clog2(CHUNKS + 1);
  localparam int SWP_W    = $clog2(BLOCKS + 1);

  // memory word: occupied bit over the next link
  localparam int WORD_W   = HANDLE_W + 1;

  // register widths and reset values
  localparam int SIZE_W   = 16;
  localparam int BPC_W    = 9;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 16'd64;
  localparam logic [BPC_W-1:0]  BPC_RST        = 9'd256;

  // config register index
  typedef enum logic {
    REG_BLOCK_SIZE = 1'b0,
    REG_BPC        = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TOO_LARGE     = 3'd1,
    ST_NO_CHUNK      = 3'd2,
    ST_FREE_IGNORED  = 3'd3,
    ST_RESET_IGNORED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_ISSUE,
    S_POP,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] block_size;
    logic [BPC_W-1:0]  blocks_per_chunk;
  } cfg_t;

endpackage
`default_nettype wire

// File: design/fbpa_ram.sv
`default_nettype none
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/fbpa_cfg.sv
`default_nettype none
module fbpa_cfg import fbpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[2]);
  assign wr     = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_size       <= BLOCK_SIZE_RST;
      cfg.blocks_per_chunk <= BPC_RST;
    end else if (wr) begin
      case (idx)
        REG_BLOCK_SIZE: cfg.block_size       <= pwdata[SIZE_W-1:0];
        REG_BPC:        cfg.blocks_per_chunk <= pwdata[BPC_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_BLOCK_SIZE: prdata = 32'(cfg.block_size);
      REG_BPC:        prdata = 32'(cfg.blocks_per_chunk);
      default:        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: design/fbpa_ctrl.sv
`default_nettype none
module fbpa_ctrl import fbpa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cfg_t                cfg,
  input  wire logic                start,
  input  wire logic [1:0]          op,
  input  wire logic [SIZE_W-1:0]   request_size,
  input  wire logic [HANDLE_W-1:0] free_handle,
  output logic                     busy,
  output logic                     done,
  output logic                     granted,
  output logic      [HANDLE_W-1:0] grant_handle,
  output logic      [2:0]          status,
  // memory side
  output logic                     mem_wr_en,
  output logic      [HANDLE_W-1:0] mem_wr_addr,
  output logic      [WORD_W-1:0]   mem_wr_data,
  output logic                     mem_rd_en,
  output logic      [HANDLE_W-1:0] mem_rd_addr,
  input  wire logic [WORD_W-1:0]   mem_rd_data
);

  state_t               state, state_next;
  logic [HANDLE_W-1:0]  list_head, list_head_next;
  logic                 head_valid, head_valid_next;
  logic [CHUNK_W-1:0]   cur_chunk, cur_chunk_next;
  logic                 cur_valid, cur_valid_next;
  logic [CNT_W-1:0]     chunks_in_use, chunks_in_use_next;
  logic [SWP_W-1:0]     sweep_idx, sweep_idx_next;
  logic [SWP_W-1:0]     eff_n, eff_n_next;
  logic                 fresh, fresh_next;
  logic [HANDLE_W-1:0]  fh, fh_next;
  logic                 done_next, granted_next;
  logic [HANDLE_W-1:0]  grant_handle_next;
  status_t              status_r, status_next;

  logic [CNT_W-1:0]     next_chunk;
  logic [SWP_W-1:0]     cfg_n;
  logic [SWP_W-1:0]     sweep_len;
  logic [SWP_W-1:0]     idx_inc;
  logic [HANDLE_W-1:0]  sweep_addr;
  logic                 rd_occ;
  logic [HANDLE_W-1:0]  rd_link;

  assign busy   = (state != S_IDLE);
  assign status = status_r;

  assign rd_occ  = mem_rd_data[HANDLE_W];
  assign rd_link = mem_rd_data[HANDLE_W-1:0];

  // blocks linked per chunk, clamped to one..BLOCKS
  always_comb begin
    if (cfg.blocks_per_chunk == '0) begin
      cfg_n = SWP_W'(1);
    end else if (cfg.blocks_per_chunk > BPC_W'(BLOCKS)) begin
      cfg_n = SWP_W'(BLOCKS);
    end else begin
      cfg_n = SWP_W'(cfg.blocks_per_chunk);
    end
  end

  // chunk to move to when the list runs dry
  assign next_chunk = cur_valid ? (CNT_W'(cur_chunk) + CNT_W'(1)) : '0;

  // a fresh chunk sweeps every slot so its occupied bits start clear
  assign sweep_len  = fresh ? SWP_W'(BLOCKS) : eff_n;
  assign idx_inc    = sweep_idx + SWP_W'(1);
  assign sweep_addr = {cur_chunk, sweep_idx[BLK_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      list_head     <= '0;
      head_valid    <= 1'b0;
      cur_chunk     <= '0;
      cur_valid     <= 1'b0;
      chunks_in_use <= '0;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      list_head     <= list_head_next;
      head_valid    <= head_valid_next;
      cur_chunk     <= cur_chunk_next;
      cur_valid     <= cur_valid_next;
      chunks_in_use <= chunks_in_use_next;
      done          <= done_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    sweep_idx    <= sweep_idx_next;
    eff_n        <= eff_n_next;
    fresh        <= fresh_next;
    fh           <= fh_next;
    granted      <= granted_next;
    grant_handle <= grant_handle_next;
    status_r     <= status_next;
  end

  // sequencer
  always_comb begin
    state_next         = state;
    list_head_next     = list_head;
    head_valid_next    = head_valid;
    cur_chunk_next     = cur_chunk;
    cur_valid_next     = cur_valid;
    chunks_in_use_next = chunks_in_use;
    sweep_idx_next     = sweep_idx;
    eff_n_next         = eff_n;
    fresh_next         = fresh;
    fh_next            = fh;
    done_next          = 1'b0;
    granted_next       = 1'b0;
    grant_handle_next  = '0;
    status_next        = ST_OK;
    mem_wr_en          = 1'b0;
    mem_wr_addr        = sweep_addr;
    mem_wr_data        = '0;
    mem_rd_en          = 1'b0;
    mem_rd_addr        = list_head;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (op_t'(op))
            OP_ALLOC: begin
              if (request_size > cfg.block_size) begin
                done_next   = 1'b1;
                status_next = ST_TOO_LARGE;
              end else if (cur_valid && head_valid) begin
                mem_rd_en  = 1'b1;
                state_next = S_POP;
              end else if (next_chunk < chunks_in_use) begin
                cur_chunk_next = next_chunk[CHUNK_W-1:0];
                cur_valid_next = 1'b1;
                fresh_next     = 1'b0;
                eff_n_next     = cfg_n;
                sweep_idx_next = '0;
                state_next     = S_OPEN;
              end else if (chunks_in_use < CNT_W'(CHUNKS)) begin
                cur_chunk_next     = chunks_in_use[CHUNK_W-1:0];
                chunks_in_use_next = chunks_in_use + CNT_W'(1);
                cur_valid_next     = 1'b1;
                fresh_next         = 1'b1;
                eff_n_next         = cfg_n;
                sweep_idx_next     = '0;
                state_next         = S_OPEN;
              end else begin
                done_next   = 1'b1;
                status_next = ST_NO_CHUNK;
              end
            end
            OP_FREE: begin
              if (CNT_W'(free_handle[HANDLE_W-1:BLK_W]) < chunks_in_use) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = free_handle;
                fh_next     = free_handle;
                state_next  = S_PUSH;
              end else begin
                done_next   = 1'b1;
                status_next = ST_FREE_IGNORED;
              end
            end
            OP_RESET: begin
              done_next = 1'b1;
              if (!cur_valid) begin
                status_next = ST_RESET_IGNORED;
              end else begin
                cur_valid_next  = 1'b0;
                cur_chunk_next  = '0;
                head_valid_next = 1'b0;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      // link the chunk one block a cycle and clear its occupied bits
      S_OPEN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sweep_addr;
        if (idx_inc < eff_n) begin
          mem_wr_data = {1'b0, sweep_addr + HANDLE_W'(1)};
        end else begin
          mem_wr_data = {1'b0, sweep_addr};
        end
        sweep_idx_next = idx_inc;
        if (idx_inc == sweep_len) begin
          list_head_next  = {cur_chunk, BLK_W'(0)};
          head_valid_next = 1'b1;
          state_next      = S_ISSUE;
        end
      end

      // read the new head
      S_ISSUE: begin
        mem_rd_en  = 1'b1;
        state_next = S_POP;
      end

      // pop: mark occupied, follow the link
      S_POP: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = list_head;
        mem_wr_data = {1'b1, rd_link};
        if (rd_link == list_head) begin
          head_valid_next = 1'b0;
        end else begin
          list_head_next = rd_link;
        end
        done_next         = 1'b1;
        granted_next      = 1'b1;
        grant_handle_next = list_head;
        state_next        = S_IDLE;
      end

      // push: only an occupied block goes back on the list
      S_PUSH: begin
        done_next = 1'b1;
        if (!rd_occ) begin
          status_next = ST_FREE_IGNORED;
        end else begin
          mem_wr_en       = 1'b1;
          mem_wr_addr     = fh;
          mem_wr_data     = {1'b0, head_valid ? list_head : fh};
          list_head_next  = fh;
          head_valid_next = 1'b1;
        end
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator. A request (allocate, free, reset) is taken
// when start is high and busy is low; its one result word appears for a single
// cycle with done high and must be captured then, since the block cannot be
// held off. Rejected requests (too large, out of chunks, free of a block in an
// unused chunk), resets and unused ops answer in the cycle after they are
// taken. An allocate from a non-empty list reads and writes back the combined
// link/occupied memory (1024 words, one write and one read port); a free of a
// block in a used chunk reads it and writes back only an occupied block. An
// allocate that finds the list empty first opens a chunk, one memory write per
// block: blocks_per_chunk blocks on reopen, all 256 the first time a chunk is
// used (clearing all its occupied bits), then pops. No clearing pass runs
// after reset. blocks_per_chunk writes take effect at the next chunk opening.
`default_nettype none
module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  // request
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op,
  input  wire logic [SIZE_W-1:0]   request_size,
  input  wire logic [HANDLE_W-1:0] free_handle,
  // result
  output logic                     done,
  output logic                     granted,
  output logic      [HANDLE_W-1:0] grant_handle,
  output logic      [2:0]          status,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready
);

  cfg_t                cfg;
  logic                mem_wr_en;
  logic [HANDLE_W-1:0] mem_wr_addr;
  logic [WORD_W-1:0]   mem_wr_data;
  logic                mem_rd_en;
  logic [HANDLE_W-1:0] mem_rd_addr;
  logic [WORD_W-1:0]   mem_rd_data;

  // config registers
  fbpa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request sequencer
  fbpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .op           (op),
    .request_size (request_size),
    .free_handle  (free_handle),
    .busy         (busy),
    .done         (done),
    .granted      (granted),
    .grant_handle (grant_handle),
    .status       (status),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data)
  );

  // link and occupied memory
  fbpa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule
`default_nettype wire

// File: bench/fixed_block_pool_allocator_test.sv
`timescale 1ns / 100ps
module fixed_block_pool_allocator_test;
  import fbpa_pkg::*;

  // one result word as the block reports it
  typedef struct packed {
    logic                granted;
    logic [HANDLE_W-1:0] handle;
    status_t             status;
  } answer_t;

  // predicted pool state and the result words still owed by the block
  class pool_tracker;
    logic [SIZE_W-1:0]   size_limit;
    logic [BPC_W-1:0]    chunk_blocks;
    logic [HANDLE_W-1:0] next_link [TOTAL];
    bit                  taken [TOTAL];
    logic [HANDLE_W-1:0] head;
    bit                  head_ok;
    int unsigned         cur_chunk;
    bit                  cur_ok;
    int unsigned         open_count;
    answer_t             pending [$];
    int                  answered;
    int                  failures;

    function new();
      size_limit   = BLOCK_SIZE_RST;
      chunk_blocks = BPC_RST;
      foreach (taken[i]) begin
        taken[i]     = 1'b0;
        next_link[i] = '0;
      end
      head       = '0;
      head_ok    = 1'b0;
      cur_chunk  = 0;
      cur_ok     = 1'b0;
      open_count = 0;
      answered   = 0;
      failures   = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void set_register(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_BLOCK_SIZE: size_limit = value[SIZE_W-1:0];
        REG_BPC:        chunk_blocks = value[BPC_W-1:0];
        default: ;
      endcase
    endfunction

    // random block that is handed out now, or -1 if none
    function int pick_taken();
      int found [$];
      foreach (taken[i]) if (taken[i]) found.push_back(i);
      if (found.size() == 0) return -1;
      return found[$urandom_range(found.size() - 1)];
    endfunction

    // work out the result word of one accepted request
    function void note_request(op_t code, logic [SIZE_W-1:0] req,
                               logic [HANDLE_W-1:0] fh);
      answer_t     a;
      int unsigned nxt;
      int unsigned span;
      int unsigned base;
      bit          ready;
      a = '0;
      a.status = ST_OK;
      case (code)
        OP_ALLOC: begin
          if (req > size_limit) begin
            a.status = ST_TOO_LARGE;
          end else begin
            ready = 1'b1;
            // list empty or rewound: move on to the next chunk or open one
            if (!cur_ok || !head_ok) begin
              nxt = cur_ok ? cur_chunk + 1 : 0;
              if (nxt < open_count) begin
                cur_chunk = nxt;
              end else if (open_count < CHUNKS) begin
                cur_chunk = open_count;
                open_count++;
              end else begin
                ready = 1'b0;
              end
              if (ready) begin
                cur_ok = 1'b1;
                span = (chunk_blocks == 0) ? 1 :
                       (chunk_blocks > BLOCKS) ? BLOCKS : chunk_blocks;
                base = cur_chunk * BLOCKS;
                // relink the chunk, last block points at itself
                for (int i = 0; i < span; i++) begin
                  taken[base + i]     = 1'b0;
                  next_link[base + i] = HANDLE_W'((i + 1 < span) ? base + i + 1 : base + i);
                end
                head    = HANDLE_W'(base);
                head_ok = 1'b1;
              end
            end
            if (!ready) begin
              a.status = ST_NO_CHUNK;
            end else begin
              taken[head] = 1'b1;
              a.granted   = 1'b1;
              a.handle    = head;
              if (next_link[head] == head) head_ok = 1'b0;
              else head = next_link[head];
            end
          end
        end
        OP_FREE: begin
          if (int'(fh) >= TOTAL || int'(fh) / BLOCKS >= open_count || !taken[fh]) begin
            a.status = ST_FREE_IGNORED;
          end else begin
            taken[fh]     = 1'b0;
            next_link[fh] = head_ok ? head : fh;
            head          = fh;
            head_ok       = 1'b1;
          end
        end
        OP_RESET: begin
          if (!cur_ok) begin
            a.status = ST_RESET_IGNORED;
          end else begin
            cur_ok    = 1'b0;
            cur_chunk = 0;
            head_ok   = 1'b0;
          end
        end
        default: ;
      endcase
      pending.push_back(a);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(logic g, logic [HANDLE_W-1:0] h, logic [2:0] s);
      answer_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result granted=%0b handle=%0d status=%0d", g, h, s));
        return;
      end
      want = pending.pop_front();
      if (g !== want.granted || h !== want.handle || s !== want.status)
        report($sformatf({"result %0d: expected granted=%0b handle=%0d status=%0d,",
                          " got granted=%0b handle=%0d status=%0d"},
                         answered, want.granted, want.handle, want.status, g, h, s));
      answered++;
    endfunction
  endclass

  // configuration plan for the random rounds
  localparam int ROUNDS = 12;
  localparam int SIZE_PLAN [ROUNDS] = '{1000, 65535, 1, 0, 64, 4096,
                                        65535, 2, 300, 1, 65535, 128};
  localparam int SPAN_PLAN [ROUNDS] = '{3, 0, 5, 2, 256, 17,
                                        1, 511, 4, 300, 9, 64};

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          op;
  logic [SIZE_W-1:0]   request_size;
  logic [HANDLE_W-1:0] free_handle;
  logic                done;
  logic                granted;
  logic [HANDLE_W-1:0] grant_handle;
  logic [2:0]          status;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  pool_tracker tracker = new();
  int          idle_pct;

  fixed_block_pool_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .request_size (request_size),
    .free_handle  (free_handle),
    .done         (done),
    .granted      (granted),
    .grant_handle (grant_handle),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result words are checked at the edge that ends their cycle
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(granted, grant_handle, status);
  end

  // hand one request word to the block, with a random gap before it
  task automatic send_request(input op_t code, input logic [SIZE_W-1:0] sz,
                              input logic [HANDLE_W-1:0] fh);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start        <= 1'b0;
      op           <= 2'($urandom);
      request_size <= SIZE_W'($urandom);
      free_handle  <= HANDLE_W'($urandom);
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start        <= 1'b1;
    op           <= code;
    request_size <= sz;
    free_handle  <= fh;
    do @(posedge clk); while (busy);
    tracker.note_request(code, sz, fh);
  endtask

  // stop sending and wait until every result word has come back
  task automatic settle();
    start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] got;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_register(idx, value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    want = (idx == REG_BLOCK_SIZE) ? 32'(value[SIZE_W-1:0]) : 32'(value[BPC_W-1:0]);
    if (got !== want)
      tracker.report($sformatf("register %0d read back %0h, expected %0h", idx, got, want));
  endtask

  // both registers, with junk in the unused upper bits
  task automatic configure(input int limit, input int span);
    write_register(REG_BLOCK_SIZE, (32'($urandom) & ~32'hFFFF) | 32'(limit));
    write_register(REG_BPC, (32'($urandom) & ~32'h1FF) | 32'(span));
  endtask

  // mostly allocate/free traffic on live blocks, some rewinds and noise
  task automatic random_item();
    int pick;
    int h;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_request(OP_ALLOC, SIZE_W'($urandom_range(int'(tracker.size_limit))),
                   HANDLE_W'($urandom));
    end else if (pick < 50) begin
      send_request(OP_ALLOC, SIZE_W'($urandom), HANDLE_W'($urandom));
    end else if (pick < 80) begin
      h = tracker.pick_taken();
      if (h < 0) h = $urandom_range(TOTAL - 1);
      send_request(OP_FREE, SIZE_W'($urandom), HANDLE_W'(h));
    end else if (pick < 88) begin
      send_request(OP_FREE, SIZE_W'($urandom), HANDLE_W'($urandom));
    end else if (pick < 96) begin
      send_request(OP_RESET, SIZE_W'($urandom), HANDLE_W'($urandom));
    end else begin
      send_request(OP_NONE, SIZE_W'($urandom), HANDLE_W'($urandom));
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    op           = '0;
    request_size = '0;
    free_handle  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_pct     = 24;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty pool: bad free, idle rewind, unused op, oversize requests
    send_request(OP_FREE, 16'd0, 10'd0);
    send_request(OP_RESET, 16'd0, 10'd0);
    send_request(OP_NONE, 16'hFFFF, 10'h3FF);
    send_request(OP_ALLOC, 16'd65, 10'd0);
    send_request(OP_ALLOC, 16'hFFFF, 10'h3FF);
    // first chunk, double free, frees outside any chunk in use
    send_request(OP_ALLOC, 16'd64, 10'd0);
    send_request(OP_ALLOC, 16'd0, 10'd0);
    send_request(OP_FREE, 16'd0, 10'd1);
    send_request(OP_FREE, 16'd0, 10'd1);
    send_request(OP_FREE, 16'd0, 10'h3FF);
    send_request(OP_FREE, 16'd0, 10'd300);
    send_request(OP_ALLOC, 16'd1, 10'd0);
    // rewind, rewind again, reopen of chunk 0
    send_request(OP_RESET, 16'd0, 10'd0);
    send_request(OP_RESET, 16'd0, 10'd0);
    send_request(OP_ALLOC, 16'd3, 10'd0);

    // one block per chunk: walk all chunks until none is left
    settle();
    configure(1, 1);
    send_request(OP_ALLOC, 16'd2, 10'd0);
    send_request(OP_ALLOC, 16'd1, 10'd0);
    send_request(OP_RESET, 16'd0, 10'd0);
    repeat (5) send_request(OP_ALLOC, 16'd0, 10'd0);
    send_request(OP_FREE, 16'd0, 10'd768);
    send_request(OP_ALLOC, 16'd1, 10'd0);
    send_request(OP_FREE, 16'd0, 10'd255);
    // block left handed out by the larger opening before
    send_request(OP_FREE, 16'd0, 10'd1);
    send_request(OP_ALLOC, 16'd1, 10'd0);

    // random rounds, sender gaps light, then heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      for (int r = 0; r < ROUNDS / 3; r++) begin
        settle();
        configure(SIZE_PLAN[ph * (ROUNDS / 3) + r], SPAN_PLAN[ph * (ROUNDS / 3) + r]);
        repeat (44) random_item();
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("** fixed_block_pool_allocator: PASSED **");
    end else begin
      $display("** fixed_block_pool_allocator: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** fixed_block_pool_allocator: FAILED **");
    $finish;
  end

endmodule
